### src/pulse_frame_climate_decoder_macros.svh
// Assertion macros used by the decoder top level.
`ifndef PULSE_FRAME_CLIMATE_DECODER_MACROS_SVH
`define PULSE_FRAME_CLIMATE_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pfcd_pkg.sv
`timescale 1ns / 1ps

package pfcd_pkg;

    localparam int FRAME_LEN  = 40;
    localparam int CNT_W      = 6;
    localparam logic [CNT_W-1:0] CNT_FRAME = 6'd40;
    localparam logic [CNT_W-1:0] CNT_SAT   = 6'd41;

    localparam int PULSE_W = 16;
    localparam int TEMP_W  = 11;
    localparam int HUMID_W = 10;
    localparam int OUT_W   = 24;

    localparam logic [15:0] SIGN_BIT = 16'h8000;
    localparam logic [15:0] MAG_MASK = 16'h7FFF;

    // Register reset values.
    localparam logic [15:0] MIN_PULSE_RST  = 16'd10;
    localparam logic [15:0] MAX_PULSE_RST  = 16'd100;
    localparam logic [15:0] ONE_THRESH_RST = 16'd50;
    localparam logic [15:0] TEMP_LOW_RST   = 16'hFE70;  // -400
    localparam logic [15:0] TEMP_HIGH_RST  = 16'd800;
    localparam logic [15:0] HUMID_HIGH_RST = 16'd1000;

    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_MIN_PULSE  = 3'd0,
        REG_MAX_PULSE  = 3'd1,
        REG_ONE_THRESH = 3'd2,
        REG_TEMP_LOW   = 3'd3,
        REG_TEMP_HIGH  = 3'd4,
        REG_HUMID_HIGH = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_TIMEOUT  = 2'd1,
        ST_CHECKSUM = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] min_pulse;
        logic [15:0] max_pulse;
        logic [15:0] one_thresh;
        logic [15:0] temp_low;
        logic [15:0] temp_high;
        logic [15:0] humid_high;
    } cfg_t;

    // A finished frame handed from the pulse stage to the check stage.
    typedef struct packed {
        logic                 timeout;
        logic [FRAME_LEN-1:0] bits;
    } frame_t;

    // Running frame state, exposed for checking.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             fault;
    } acc_stat_t;

endpackage

### src/pfcd_cfg_regs.sv
`timescale 1ns / 1ps

module pfcd_cfg_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [pfcd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output pfcd_pkg::cfg_t            cfg
);

    pfcd_pkg::cfg_t cfg_reg;
    pfcd_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [2:0]     idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[pfcd_pkg::ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                pfcd_pkg::REG_MIN_PULSE:  cfg_next.min_pulse  = pwdata[15:0];
                pfcd_pkg::REG_MAX_PULSE:  cfg_next.max_pulse  = pwdata[15:0];
                pfcd_pkg::REG_ONE_THRESH: cfg_next.one_thresh = pwdata[15:0];
                pfcd_pkg::REG_TEMP_LOW:   cfg_next.temp_low   = pwdata[15:0];
                pfcd_pkg::REG_TEMP_HIGH:  cfg_next.temp_high  = pwdata[15:0];
                pfcd_pkg::REG_HUMID_HIGH: cfg_next.humid_high = pwdata[15:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_pulse  <= pfcd_pkg::MIN_PULSE_RST;
            cfg_reg.max_pulse  <= pfcd_pkg::MAX_PULSE_RST;
            cfg_reg.one_thresh <= pfcd_pkg::ONE_THRESH_RST;
            cfg_reg.temp_low   <= pfcd_pkg::TEMP_LOW_RST;
            cfg_reg.temp_high  <= pfcd_pkg::TEMP_HIGH_RST;
            cfg_reg.humid_high <= pfcd_pkg::HUMID_HIGH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Signed limits read back sign-extended.
    always_comb begin
        case (idx)
            pfcd_pkg::REG_MIN_PULSE:  prdata = {16'd0, cfg_reg.min_pulse};
            pfcd_pkg::REG_MAX_PULSE:  prdata = {16'd0, cfg_reg.max_pulse};
            pfcd_pkg::REG_ONE_THRESH: prdata = {16'd0, cfg_reg.one_thresh};
            pfcd_pkg::REG_TEMP_LOW:   prdata = {{16{cfg_reg.temp_low[15]}}, cfg_reg.temp_low};
            pfcd_pkg::REG_TEMP_HIGH:  prdata = {{16{cfg_reg.temp_high[15]}}, cfg_reg.temp_high};
            pfcd_pkg::REG_HUMID_HIGH: prdata = {16'd0, cfg_reg.humid_high};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

### src/pfcd_pulse_acc.sv
`timescale 1ns / 1ps

module pfcd_pulse_acc (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pfcd_pkg::cfg_t              cfg,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [pfcd_pkg::PULSE_W-1:0] s_tdata,
    input  logic                        s_tlast,
    input  logic                        frm_take,
    output logic                        frm_valid,
    output pfcd_pkg::frame_t            frm,
    output pfcd_pkg::acc_stat_t         stat
);

    logic [pfcd_pkg::FRAME_LEN-1:0] bits_reg, bits_next;
    logic [pfcd_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           fault_reg, fault_next;
    logic                           frm_vld_reg, frm_vld_next;
    pfcd_pkg::frame_t               frm_reg, frm_next;

    logic accept;
    logic bad_pulse;
    logic bit_val;
    logic [pfcd_pkg::FRAME_LEN-1:0] bits_in;
    logic [pfcd_pkg::CNT_W-1:0]     cnt_in;
    logic                           fault_in;

    assign s_tready  = !frm_vld_reg || frm_take;
    assign accept    = s_tvalid && s_tready;
    assign frm_valid = frm_vld_reg;
    assign frm       = frm_reg;
    assign stat      = '{count: cnt_reg, fault: fault_reg};

    assign bad_pulse = (s_tdata < cfg.min_pulse) || (s_tdata > cfg.max_pulse);
    assign bit_val   = (s_tdata >= cfg.one_thresh);
    assign bits_in   = {bits_reg[pfcd_pkg::FRAME_LEN-2:0], bit_val};
    assign cnt_in    = (cnt_reg < pfcd_pkg::CNT_SAT) ? cnt_reg + 1'b1 : cnt_reg;
    assign fault_in  = fault_reg || bad_pulse;

    always_comb begin
        bits_next    = bits_reg;
        cnt_next     = cnt_reg;
        fault_next   = fault_reg;
        frm_next     = frm_reg;
        frm_vld_next = frm_vld_reg && !frm_take;
        if (accept) begin
            if (s_tlast) begin
                // Hand the finished frame on and start a fresh one.
                frm_next.bits    = bits_in;
                frm_next.timeout = fault_in || (cnt_in != pfcd_pkg::CNT_FRAME);
                frm_vld_next     = 1'b1;
                bits_next        = '0;
                cnt_next         = '0;
                fault_next       = 1'b0;
            end else begin
                bits_next  = bits_in;
                cnt_next   = cnt_in;
                fault_next = fault_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg    <= '0;
            cnt_reg     <= '0;
            fault_reg   <= 1'b0;
            frm_vld_reg <= 1'b0;
        end else begin
            bits_reg    <= bits_next;
            cnt_reg     <= cnt_next;
            fault_reg   <= fault_next;
            frm_vld_reg <= frm_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        frm_reg <= frm_next;
    end

endmodule

### src/pfcd_frame_check.sv
`timescale 1ns / 1ps

module pfcd_frame_check (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pfcd_pkg::cfg_t            cfg,
    input  logic                      frm_valid,
    input  pfcd_pkg::frame_t          frm,
    output logic                      frm_take,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [pfcd_pkg::OUT_W-1:0] m_tdata
);

    logic                         out_vld_reg, out_vld_next;
    logic [pfcd_pkg::OUT_W-1:0]   out_reg, out_next;

    logic [7:0]  b0, b1, b2, b3, ck, sum;
    logic [15:0] raw_h, raw_t;
    logic signed [15:0] temp;
    logic        out_of_range;
    pfcd_pkg::status_t status;
    logic [pfcd_pkg::TEMP_W-1:0]  temp_out;
    logic [pfcd_pkg::HUMID_W-1:0] humid_out;

    assign frm_take = frm_valid && (!out_vld_reg || m_tready);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    assign b0  = frm.bits[39:32];
    assign b1  = frm.bits[31:24];
    assign b2  = frm.bits[23:16];
    assign b3  = frm.bits[15:8];
    assign ck  = frm.bits[7:0];
    assign sum = b0 + b1 + b2 + b3;

    assign raw_h = {b0, b1};
    assign raw_t = {b2, b3};
    // Sign-magnitude temperature; a negative zero comes out as zero.
    assign temp = ((raw_t & pfcd_pkg::SIGN_BIT) != 16'd0)
                ? -$signed(raw_t & pfcd_pkg::MAG_MASK)
                : $signed(raw_t);

    assign out_of_range = (temp < $signed(cfg.temp_low)) || (temp > $signed(cfg.temp_high))
                       || (raw_h > cfg.humid_high);

    always_comb begin
        status    = pfcd_pkg::ST_VALID;
        temp_out  = '0;
        humid_out = '0;
        if (frm.timeout) begin
            status = pfcd_pkg::ST_TIMEOUT;
        end else if (sum != ck) begin
            status = pfcd_pkg::ST_CHECKSUM;
        end else if (out_of_range) begin
            status = pfcd_pkg::ST_RANGE;
        end else begin
            temp_out  = temp[pfcd_pkg::TEMP_W-1:0];
            humid_out = raw_h[pfcd_pkg::HUMID_W-1:0];
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg && !m_tready;
        out_next     = out_reg;
        if (frm_take) begin
            out_vld_next = 1'b1;
            out_next     = {1'b0, humid_out, temp_out, status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

endmodule

### src/pulse_frame_climate_decoder.sv
`timescale 1ns / 1ps
// Channel   | Direction | Carries
// ----------+-----------+--------------------------------------------------
// s_*       | in        | one pulse width per item, tlast on the frame's end
// m_*       | out       | one decode result per frame
// APB       | in/out    | six 16-bit limit registers at byte address 4*i
//
// One pulse item can be accepted in every cycle. The last pulse of a frame
// is registered with its frame in the frame register, and the result register
// loads from it when the check stage takes the frame, raising m_tvalid.
// Reset (aresetn low at a clock edge) clears the frame in progress and both
// valid flags and returns the limit registers to their reset values. s_tready
// drops only while a finished frame waits behind a result that m_tready holds.

`include "pulse_frame_climate_decoder_macros.svh"

module pulse_frame_climate_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // Pulse input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] pulse_us
    input  logic        s_tlast,    // last_pulse
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [1:0] status, [12:2] temperature_tenths,
                                    // [22:13] humidity_tenths, [23] zero
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pfcd_pkg::cfg_t      cfg;
    pfcd_pkg::frame_t    frm;
    pfcd_pkg::acc_stat_t stat;
    logic                frm_valid;
    logic                frm_take;

    // Limit registers; the user must change them only while no frame is in flight (not enforced here).
    pfcd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Classifies each pulse, shifts the bit in, and counts pulses. The last
    // pulse hands the complete frame and its timeout flag to the check stage.
    pfcd_pulse_acc u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .frm_take  (frm_take),
        .frm_valid (frm_valid),
        .frm       (frm),
        .stat      (stat)
    );

    // Checksum, sign-magnitude decode and range checks, then the result
    // register that drives the output channel.
    pfcd_frame_check u_chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .frm_valid (frm_valid),
        .frm       (frm),
        .frm_take  (frm_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // A frame taken by the check stage is on the output in the next cycle.
    `PFCD_ASSERT_NEXT(a_take_shows, aclk, aresetn, frm_take, m_tvalid, "taken frame lost")

    // The last pulse always leaves a cleared frame behind it.
    `PFCD_ASSERT_NEXT(a_last_clears, aclk, aresetn, s_tvalid && s_tready && s_tlast,
        (stat.count == '0) && !stat.fault, "frame not cleared after last pulse")

    // Any result other than valid carries zero data.
    `PFCD_ASSERT_NOW(a_bad_zero, aclk, aresetn,
        m_tvalid && (m_tdata[1:0] != pfcd_pkg::ST_VALID),
        m_tdata[23:2] == '0, "non-valid result carries data")

    // The pulse count saturates and never runs past its ceiling.
    `PFCD_ASSERT_NOW(a_cnt_sat, aclk, aresetn, 1'b1,
        stat.count <= pfcd_pkg::CNT_SAT, "pulse count beyond saturation")

endmodule

### tb/pulse_frame_climate_decoder_tb.sv
`timescale 1ns / 1ps

module pulse_frame_climate_decoder_tb;

    // Cycles without any accepted item before the run is declared hung. The
    // longest quiet stretch of a correct run is the deliberate output hold,
    // so this leaves a wide margin.
    localparam int STALL_LIMIT = 5000;
    // Cycles to let the two pipeline stages empty before touching registers.
    localparam int SETTLE_CYCLES = 4;
    // Length of the deliberate hold on m_tready that backs the block up.
    localparam int HOLD_CYCLES = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] pulse_us
    logic        s_tlast;   // last_pulse
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [1:0] status, [12:2] temperature_tenths,
                            // [22:13] humidity_tenths, [23] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Idle rates in percent, changed by the main sequence between phases.
    int send_idle_pct;
    int recv_idle_pct;
    // Set by the main sequence to ask the receiver for one long hold.
    bit hold_req;

    pulse_frame_climate_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Expected content of one result item.
    typedef struct {
        pfcd_pkg::status_t status;
        logic [10:0]       temp;
        logic [9:0]        humid;
    } reading_t;

    // Tracks the frame being assembled and the readings it must produce.
    class climate_scoreboard;
        logic [15:0] min_us;
        logic [15:0] max_us;
        logic [15:0] one_us;
        int          temp_low;
        int          temp_high;
        logic [15:0] humid_high;

        logic [39:0] frame;
        logic [5:0]  count;
        bit          fault;

        reading_t readings[$];
        int       frames_decoded;
        int       checked;
        int       errors;

        function new();
            min_us     = pfcd_pkg::MIN_PULSE_RST;
            max_us     = pfcd_pkg::MAX_PULSE_RST;
            one_us     = pfcd_pkg::ONE_THRESH_RST;
            temp_low   = $signed(pfcd_pkg::TEMP_LOW_RST);
            temp_high  = $signed(pfcd_pkg::TEMP_HIGH_RST);
            humid_high = pfcd_pkg::HUMID_HIGH_RST;
            frame      = '0;
            count      = '0;
            fault      = 1'b0;
        endfunction

        function void set_limit(pfcd_pkg::reg_idx_t idx, logic [15:0] value);
            case (idx)
                pfcd_pkg::REG_MIN_PULSE:  min_us = value;
                pfcd_pkg::REG_MAX_PULSE:  max_us = value;
                pfcd_pkg::REG_ONE_THRESH: one_us = value;
                pfcd_pkg::REG_TEMP_LOW:   temp_low = $signed(value);
                pfcd_pkg::REG_TEMP_HIGH:  temp_high = $signed(value);
                pfcd_pkg::REG_HUMID_HIGH: humid_high = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return readings.size();
        endfunction

        // Folds one accepted pulse into the frame; the last pulse of a frame
        // yields the reading the block must emit.
        function void decode_pulse(logic [15:0] pulse, logic last);
            reading_t    want;
            logic [15:0] raw_h;
            logic [15:0] raw_t;
            logic [7:0]  sum;
            int          t;
            if (pulse < min_us || pulse > max_us) fault = 1'b1;
            frame = {frame[38:0], pulse >= one_us};
            if (count < pfcd_pkg::CNT_SAT) count++;
            if (!last) return;
            want.status = pfcd_pkg::ST_VALID;
            want.temp   = '0;
            want.humid  = '0;
            raw_h = frame[39:24];
            raw_t = frame[23:8];
            sum   = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
            if (fault || count != pfcd_pkg::CNT_FRAME) begin
                want.status = pfcd_pkg::ST_TIMEOUT;
            end else if (sum != frame[7:0]) begin
                want.status = pfcd_pkg::ST_CHECKSUM;
            end else begin
                // Sign-magnitude temperature; a set sign with zero magnitude is zero.
                t = raw_t[15] ? -int'(raw_t[14:0]) : int'(raw_t);
                if (t < temp_low || t > temp_high || raw_h > humid_high) begin
                    want.status = pfcd_pkg::ST_RANGE;
                end else begin
                    want.temp  = t[10:0];
                    want.humid = raw_h[9:0];
                end
            end
            readings.push_back(want);
            frames_decoded++;
            frame = '0;
            count = '0;
            fault = 1'b0;
        endfunction

        task report(string field, int unsigned got, int unsigned want);
            $display("mismatch in result %0d, %s: got 0x%0h, expected 0x%0h",
                     checked, field, got, want);
            errors++;
        endtask

        task check_reading(logic [23:0] word);
            reading_t want;
            if (readings.size() == 0) begin
                report("no result expected", word, 0);
                return;
            end
            want = readings.pop_front();
            if (word[1:0] != want.status) report("status", word[1:0], want.status);
            if (word[12:2] != want.temp) report("temperature", word[12:2], want.temp);
            if (word[22:13] != want.humid) report("humidity", word[22:13], want.humid);
            if (word[23] != 1'b0) report("pad bit", word[23], 0);
            checked++;
        endtask
    endclass

    climate_scoreboard sb = new();

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Offers one pulse item, idling first at the sender's current rate, and
    // returns at the edge where the block takes it.
    task automatic send_pulse(input logic [15:0] pulse, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pulse;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.decode_pulse(pulse, last);
    endtask

    // A width that the current limits class as the given bit, often at an
    // edge of its range. When no in-range width exists any width will do.
    function automatic logic [15:0] width_for_bit(logic b);
        int lo;
        int hi;
        if (b) begin
            lo = (sb.one_us > sb.min_us) ? sb.one_us : sb.min_us;
            hi = sb.max_us;
        end else begin
            lo = sb.min_us;
            hi = int'(sb.one_us) - 1;
            if (hi > sb.max_us) hi = sb.max_us;
        end
        if (lo > hi) return 16'($urandom);
        case ($urandom_range(0, 7))
            0: return 16'(lo);
            1: return 16'(hi);
            default: return 16'($urandom_range(hi, lo));
        endcase
    endfunction

    // A width outside [min, max] where the limits leave room for one.
    function automatic logic [15:0] faulty_width();
        if (sb.min_us > 0) return 16'($urandom_range(0, sb.min_us - 1));
        if (sb.max_us < 16'hFFFF) return 16'($urandom_range(sb.max_us + 1, 65535));
        return 16'($urandom);
    endfunction

    // Builds a 40-bit frame: humidity, temperature, checksum from the top.
    // Most frames aim at a valid reading; some hit the limits exactly, carry
    // a negative zero, random raw fields, or a corrupted checksum.
    function automatic logic [39:0] compose_frame();
        logic [15:0] hum;
        logic [15:0] traw;
        logic [7:0]  sum;
        int          t;
        int          kind;
        kind = $urandom_range(0, 9);
        hum  = 16'($urandom_range(0, sb.humid_high));
        if (sb.temp_low <= sb.temp_high)
            t = sb.temp_low + int'($urandom_range(0, sb.temp_high - sb.temp_low));
        else
            t = sb.temp_low;
        if (kind == 5) begin
            t   = $urandom_range(0, 1) ? sb.temp_low : sb.temp_high;
            hum = $urandom_range(0, 1) ? sb.humid_high : 16'd0;
        end
        traw = (t < 0) ? {1'b1, 15'(-t)} : 16'(t);
        if (kind == 6) traw = 16'h8000;
        if (kind >= 7) begin
            hum  = 16'($urandom);
            traw = 16'($urandom);
        end
        sum = hum[15:8] + hum[7:0] + traw[15:8] + traw[7:0];
        if ($urandom_range(0, 7) == 0) sum = sum + 8'($urandom_range(1, 255));
        return {hum, traw, sum};
    endfunction

    // Sends a frame MSB first as n pulses; pulses past the 40th carry random
    // bits. The pulse at index bad_at, if any, is made out of range.
    task automatic send_frame(input logic [39:0] bits, input int n, input int bad_at);
        logic        b;
        logic [15:0] width;
        for (int i = 0; i < n; i++) begin
            b     = (i < 40) ? bits[39 - i] : 1'($urandom_range(0, 1));
            width = (i == bad_at) ? faulty_width() : width_for_bit(b);
            send_pulse(width, i == n - 1);
        end
    endtask

    // Mostly well-formed frames with random content; the rest are frames of
    // the wrong length and short runs of random pulses.
    task automatic run_random(input int min_items, input int min_frames);
        int items_sent;
        int first_frame;
        int pick;
        int n;
        int bad_at;
        items_sent  = 0;
        first_frame = sb.frames_decoded;
        while (items_sent < min_items || sb.frames_decoded - first_frame < min_frames) begin
            pick = $urandom_range(0, 19);
            if (pick < 11) begin
                bad_at = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 39)) : -1;
                send_frame(compose_frame(), 40, bad_at);
                items_sent += 40;
            end else if (pick < 13) begin
                n = $urandom_range(0, 1) ? $urandom_range(36, 39) : $urandom_range(41, 45);
                send_frame(compose_frame(), n, -1);
                items_sent += n;
            end else begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++) send_pulse(16'($urandom), k == n - 1);
                items_sent += n;
            end
        end
    endtask

    // Stops offering items and waits until every reading has come out and
    // the pipeline is empty, so registers can be changed safely.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One APB write: setup cycle, then access cycle until pready. The select
    // is left high so that writes can follow back to back.
    task automatic write_limit(input pfcd_pkg::reg_idx_t idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_limit(idx, value);
    endtask

    // Writes all six limits for one of the register settings.
    task automatic load_limits(input int setting);
        logic [15:0] lim[6];
        case (setting)
            0: lim = '{16'd10, 16'd100, 16'd50, 16'hFE70, 16'd800, 16'd1000};
            // Wide limits: valid readings exceed the output field widths.
            1: lim = '{16'd0, 16'hFFFF, 16'h8000, 16'h8001, 16'h7FFF, 16'hFFFF};
            2: lim = '{16'd20, 16'd200, 16'd100, 16'hFF9C, 16'd300, 16'd500};
            // Minimum above maximum: every pulse is out of range.
            3: lim = '{16'd500, 16'd400, 16'hFFFF, 16'hFE70, 16'd800, 16'd1000};
            // Inverted temperature window: no reading can be in range.
            4: lim = '{16'd0, 16'hFFFF, 16'd1, 16'h7FFF, 16'h8001, 16'd0};
            default: begin
                lim[0] = 16'($urandom_range(0, 300));
                lim[2] = lim[0] + 16'($urandom_range(1, 300));
                lim[1] = lim[2] + 16'($urandom_range(0, 300));
                lim[3] = 16'(-int'($urandom_range(0, 2000)));
                lim[4] = 16'($urandom_range(0, 2000));
                lim[5] = 16'($urandom_range(0, 1500));
            end
        endcase
        write_limit(pfcd_pkg::REG_MIN_PULSE, lim[0]);
        write_limit(pfcd_pkg::REG_MAX_PULSE, lim[1]);
        write_limit(pfcd_pkg::REG_ONE_THRESH, lim[2]);
        write_limit(pfcd_pkg::REG_TEMP_LOW, lim[3]);
        write_limit(pfcd_pkg::REG_TEMP_HIGH, lim[4]);
        write_limit(pfcd_pkg::REG_HUMID_HIGH, lim[5]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Result side: every accepted item is checked against the oldest reading.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_reading(m_tdata);
    end

    // Receiver: random stalls at the current rate, plus one long hold on
    // request, counted here so the sender keeps offering items meanwhile.
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run if no item moves on either channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("pulse_frame_climate_decoder regression: fail");
        $finish;
    end

    // Main sequence: reset, a short directed part on the reset limits, then
    // six register settings with random frames, under three idle patterns.
    initial begin
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        aresetn  <= 1'b0;
        hold_req = 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 63;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single-pulse frames at the width extremes: too short a count.
        send_pulse(16'd0, 1'b1);
        send_pulse(16'hFFFF, 1'b1);
        // Widths at both limits and around the threshold, ending on a pulse
        // just under the minimum.
        send_pulse(16'd10, 1'b0);
        send_pulse(16'd100, 1'b0);
        send_pulse(16'd49, 1'b0);
        send_pulse(16'd50, 1'b0);
        send_pulse(16'd9, 1'b1);
        // A pulse just over the maximum, then a good last pulse.
        send_pulse(16'd101, 1'b0);
        send_pulse(16'd50, 1'b1);
        // Alternating bit patterns on the pulse field.
        send_pulse(16'h5555, 1'b0);
        send_pulse(16'hAAAA, 1'b1);
        send_pulse(16'd1, 1'b1);
        drain();

        for (int setting = 0; setting < 6; setting++) begin
            if (setting == 2) begin
                send_idle_pct = 63;
                recv_idle_pct = 26;
            end
            if (setting == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_limits(setting);
            if (setting == 4) begin
                // Hold the output while short frames keep coming, so the
                // block fills up and must stall its input.
                hold_req = 1'b1;
                repeat (30) send_pulse(16'($urandom), 1'b1);
            end
            run_random(140, 4);
            drain();
        end

        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("pulse_frame_climate_decoder regression: pass");
        end else begin
            $display("pulse_frame_climate_decoder regression: fail");
        end
        $finish;
    end

endmodule
